FILE: design/wbs_pkg.sv
// Package for the windowed bitrate statistics core: payload types, constants,
// register indexes and sequencer states. No dependencies.
package wbs_pkg;

    localparam int TS_BITS = 40;

    localparam logic [39:0] RST_WINDOW_TICKS = 40'd90000;
    localparam logic [31:0] RST_TICKS_PER_SEC = 32'd90000;
    localparam logic [7:0]  RST_FALLBACK_FPS = 8'd30;

    localparam logic [1:0] REG_WINDOW_TICKS = 2'd0;
    localparam logic [1:0] REG_TICKS_PER_SEC = 2'd1;
    localparam logic [1:0] REG_FALLBACK_FPS = 2'd2;

    localparam logic [39:0] M40 = {40{1'b1}};

    typedef struct packed {
        logic [23:0]        frame_bytes;
        logic [TS_BITS-1:0] frame_timestamp;
        logic               last_frame;
    } t_in_beat;

    typedef struct packed {
        logic        result_kind;
        logic [39:0] window_start;
        logic [39:0] window_bitrate;
        logic [39:0] average_bitrate;
        logic [39:0] min_bitrate;
        logic [39:0] max_bitrate;
        logic [39:0] std_deviation;
        logic        last_result;
    } t_out_beat;

    // Commands to the shared divider.
    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [63:0]  den;
    } t_div_req;

    typedef struct packed {
        logic         done;
        logic [127:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_WR_MUL,
        S_WR_DIV,
        S_WR_WAIT,
        S_WR_SQ,
        S_WR_EMIT,
        S_WR_OUT,
        S_ACC,
        S_AV_MUL,
        S_AV_DIV,
        S_AV_WAIT,
        S_SD_SQ,
        S_SD_MA,
        S_SD_MB,
        S_SD_MC,
        S_SD_SUB,
        S_SD_DIV,
        S_SD_WAIT,
        S_SQ_STEP,
        S_SUM_OUT
    } t_state;

endpackage

FILE: design/wbs_mul.sv
// Shared 64 by 64 multiplier built from one 32 by 32 product a cycle.
// Depends on nothing but the clock domain of the core.
module wbs_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    logic [63:0]  r_a, r_b;
    logic [2:0]   r_step;
    logic         r_busy;
    logic [127:0] r_acc;
    logic [31:0]  w_x, w_y;
    logic [63:0]  w_p;
    logic [127:0] w_sh;

    always_comb begin
        unique case (r_step[1:0])
            2'd0: begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            2'd1: begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            2'd2: begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            default: begin w_x = r_a[63:32]; w_y = r_b[63:32]; end
        endcase
        w_p = 64'(w_x) * 64'(w_y);
        unique case (r_step[1:0])
            2'd0: w_sh = {64'd0, w_p};
            2'd1, 2'd2: w_sh = {32'd0, w_p, 32'd0};
            default: w_sh = {w_p, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_a <= i_a;
                r_b <= i_b;
                r_acc <= '0;
                r_step <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + w_sh;
                r_step <= r_step + 3'd1;
                if (r_step == 3'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_acc;
endmodule

FILE: design/wbs_div.sv
// Shared restoring divider, 128-bit dividend by 64-bit divisor, one quotient
// bit a cycle. Uses the request and response structs of wbs_pkg.
module wbs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wbs_pkg::t_div_req i_req,
    output wbs_pkg::t_div_rsp o_rsp
);
    logic [127:0] r_n;
    logic [63:0]  r_d, r_rem;
    logic [7:0]   r_cnt;
    logic         r_busy, r_done;
    logic [64:0]  w_sh;
    logic         w_ge;

    assign w_sh = {r_rem, r_n[127]};
    assign w_ge = w_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= 8'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_n <= i_req.num;
                r_d <= i_req.den;
                r_rem <= '0;
                r_cnt <= 8'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? 64'(w_sh - {1'b0, r_d}) : w_sh[63:0];
                r_n <= {r_n[126:0], w_ge};
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_n;
endmodule

FILE: design/windowed_bitrate_stats_core.sv
// Windowed bitrate statistics core. Depends on wbs_pkg, wbs_mul and wbs_div.
//
// Frames enter one at a time and are grouped into tumbling windows. A frame
// that lands outside the open window closes it and yields a window beat
// (start timestamp and bitrate); a frame flagged last also closes its window
// and yields a summary beat (average, minimum, maximum and standard
// deviation of the window rates), after which all stream state clears. The
// block takes one frame and works on it alone: o_in_stall is low only while
// the sequencer is idle. A frame that closes nothing keeps the input stalled
// through the CHECK and ACC states. A closed window uses the bit-serial
// divider once and the multiplier twice; a summary adds two more divisions,
// five multiplications and a 64-step square root in which each step uses the
// multiplier once. Result beats sit in an output register, and the sequencer
// waits there while the receiver stalls. Configuration writes are taken at any
// time but are meant for when the block is idle.
module windowed_bitrate_stats_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  wbs_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output wbs_pkg::t_out_beat o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [39:0]       i_cfg_data
);
    // Configuration registers.
    logic [39:0] r_window_ticks;
    logic [31:0] r_ticks_per_sec;
    logic [7:0]  r_fallback_fps;

    // Stream state.
    logic         r_win_open;
    logic [39:0]  r_win_first, r_win_last;
    logic [47:0]  r_win_bytes;
    logic [31:0]  r_win_cnt;
    logic [39:0]  r_st_first, r_st_last;
    logic [55:0]  r_st_bytes;
    logic [31:0]  r_st_cnt;
    logic [31:0]  r_wcount;
    logic [39:0]  r_lo_rate, r_hi_rate;
    logic [63:0]  r_rate_sum;
    logic [127:0] r_sq_sum;

    // Working registers.
    wbs_pkg::t_in_beat r_in;
    wbs_pkg::t_state   r_state, n_state;
    logic [39:0]  r_rate, r_avg;
    logic [127:0] r_tmp, r_num;
    logic [63:0]  r_sq_res;
    logic [5:0]   r_bit;
    logic         r_sd_ok;
    logic         r_sq_kick;
    // Set while the registered frame has not yet been merged into the window.
    logic         r_win_is_last;

    // Shared units.
    logic         w_mul_start, w_mul_done;
    logic [63:0]  w_mul_a, w_mul_b;
    logic [127:0] w_mul_p;
    wbs_pkg::t_div_req w_div_req;
    wbs_pkg::t_div_rsp w_div_rsp;

    wbs_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start),
        .i_a(w_mul_a), .i_b(w_mul_b), .o_done(w_mul_done), .o_prod(w_mul_p)
    );

    wbs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_div_req), .o_rsp(w_div_rsp)
    );

    // A zero rate register or a zero frame count forces a rate of zero.
    function automatic logic r_win_span_ok(input logic span, input logic [31:0] tps,
                                           input logic [7:0] fps, input logic [31:0] cnt);
        r_win_span_ok = span ? (tps != '0) : ((fps != '0) && (cnt != '0));
    endfunction

    // Window membership test on the registered frame.
    logic [39:0] w_len;
    logic [40:0] w_end;
    logic        w_inside, w_close_first;
    assign w_len = (r_window_ticks == 40'd0) ? 40'd1 : r_window_ticks;
    assign w_end = {1'b0, r_win_first} + {1'b0, w_len};
    assign w_inside = w_end[40] || ({1'b0, r_in.frame_timestamp} < w_end);
    assign w_close_first = r_win_open && !w_inside;

    // Rate selection for the window being closed and for the whole stream.
    logic w_win_span, w_st_span;
    assign w_win_span = r_win_last > r_win_first;
    assign w_st_span = r_st_last > r_st_first;

    logic w_out_take;
    assign w_out_take = o_out_valid && !i_out_stall;

    logic [39:0] w_q_sat;
    assign w_q_sat = (w_div_rsp.quo[127:40] != '0) ? wbs_pkg::M40 : w_div_rsp.quo[39:0];

    // Square root candidate for the current bit.
    logic [63:0] w_cand;
    assign w_cand = r_sq_res | (64'd1 << r_bit);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wbs_pkg::S_IDLE:    if (i_in_valid) n_state = wbs_pkg::S_CHECK;
            wbs_pkg::S_CHECK:   if (w_close_first) n_state = wbs_pkg::S_WR_MUL;
                                else n_state = wbs_pkg::S_ACC;
            wbs_pkg::S_WR_MUL:  n_state = wbs_pkg::S_WR_DIV;
            wbs_pkg::S_WR_DIV:  if (w_mul_done) n_state = wbs_pkg::S_WR_WAIT;
            wbs_pkg::S_WR_WAIT: if (w_div_rsp.done) n_state = wbs_pkg::S_WR_SQ;
            wbs_pkg::S_WR_SQ:   n_state = wbs_pkg::S_WR_EMIT;
            wbs_pkg::S_WR_EMIT: if (w_mul_done) n_state = wbs_pkg::S_WR_OUT;
            wbs_pkg::S_WR_OUT:  if (w_out_take) n_state = wbs_pkg::S_ACC;
            wbs_pkg::S_ACC: begin
                if (r_in.last_frame && r_win_is_last) n_state = wbs_pkg::S_WR_MUL;
                else if (r_in.last_frame) n_state = wbs_pkg::S_AV_MUL;
                else n_state = wbs_pkg::S_IDLE;
            end
            wbs_pkg::S_AV_MUL:  n_state = wbs_pkg::S_AV_DIV;
            wbs_pkg::S_AV_DIV:  if (w_mul_done) n_state = wbs_pkg::S_AV_WAIT;
            wbs_pkg::S_AV_WAIT: if (w_div_rsp.done) n_state = wbs_pkg::S_SD_SQ;
            wbs_pkg::S_SD_SQ:   n_state = wbs_pkg::S_SD_MA;
            wbs_pkg::S_SD_MA:   if (w_mul_done) n_state = wbs_pkg::S_SD_MB;
            wbs_pkg::S_SD_MB:   if (w_mul_done) n_state = wbs_pkg::S_SD_MC;
            wbs_pkg::S_SD_MC:   if (w_mul_done) n_state = wbs_pkg::S_SD_SUB;
            wbs_pkg::S_SD_SUB:  if (w_mul_done) n_state = wbs_pkg::S_SD_DIV;
            wbs_pkg::S_SD_DIV:  n_state = r_sd_ok ? wbs_pkg::S_SD_WAIT : wbs_pkg::S_SQ_STEP;
            wbs_pkg::S_SD_WAIT: if (w_div_rsp.done) n_state = wbs_pkg::S_SQ_STEP;
            wbs_pkg::S_SQ_STEP: if (w_mul_done && r_bit == 6'd0) n_state = wbs_pkg::S_SUM_OUT;
            wbs_pkg::S_SUM_OUT: if (w_out_take) n_state = wbs_pkg::S_IDLE;
            default:            n_state = wbs_pkg::S_IDLE;
        endcase
    end

    // Unit commands.
    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a = '0;
        w_mul_b = '0;
        w_div_req = '0;
        unique case (r_state)
            wbs_pkg::S_WR_MUL: begin
                w_mul_start = 1'b1;
                w_mul_a = {13'd0, r_win_bytes, 3'd0};
                w_mul_b = w_win_span ? {32'd0, r_ticks_per_sec} : {56'd0, r_fallback_fps};
            end
            wbs_pkg::S_WR_DIV: begin
                w_div_req.start = w_mul_done;
                w_div_req.num = w_mul_p;
                w_div_req.den = w_win_span ? {24'd0, 40'(r_win_last - r_win_first)}
                                           : {32'd0, r_win_cnt};
            end
            wbs_pkg::S_WR_SQ: begin
                w_mul_start = 1'b1;
                w_mul_a = {24'd0, r_rate};
                w_mul_b = {24'd0, r_rate};
            end
            wbs_pkg::S_AV_MUL: begin
                w_mul_start = 1'b1;
                w_mul_a = {5'd0, r_st_bytes, 3'd0};
                w_mul_b = w_st_span ? {32'd0, r_ticks_per_sec} : {56'd0, r_fallback_fps};
            end
            wbs_pkg::S_AV_DIV: begin
                w_div_req.start = w_mul_done;
                w_div_req.num = w_mul_p;
                w_div_req.den = w_st_span ? {24'd0, 40'(r_st_last - r_st_first)}
                                          : {32'd0, r_st_cnt};
            end
            wbs_pkg::S_SD_SQ: begin
                w_mul_start = 1'b1;
                w_mul_a = {24'd0, r_avg};
                w_mul_b = {24'd0, r_avg};
            end
            wbs_pkg::S_SD_MA: begin
                // Low 64 bits of the squared average times the window count.
                w_mul_start = w_mul_done;
                w_mul_a = w_mul_p[63:0];
                w_mul_b = {32'd0, r_wcount};
            end
            wbs_pkg::S_SD_MB: begin
                // Top 16 bits of the squared average times the window count.
                w_mul_start = w_mul_done;
                w_mul_a = {48'd0, r_tmp[79:64]};
                w_mul_b = {32'd0, r_wcount};
            end
            wbs_pkg::S_SD_MC: begin
                w_mul_start = w_mul_done;
                w_mul_a = {23'd0, r_avg, 1'b0};
                w_mul_b = r_rate_sum;
            end
            wbs_pkg::S_SD_DIV: begin
                w_div_req.start = r_sd_ok;
                w_div_req.num = r_num - r_tmp;
                w_div_req.den = {32'd0, r_wcount};
            end
            wbs_pkg::S_SQ_STEP: begin
                w_mul_start = r_sq_kick;
                w_mul_a = w_cand;
                w_mul_b = w_cand;
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_out_take) begin
            o_out_valid <= 1'b0;
        end else if (r_state == wbs_pkg::S_WR_EMIT && w_mul_done) begin
            // The window beat ends the frame's beats unless a summary follows.
            o_out_valid <= 1'b1;
            o_out_data <= '{window_start: r_win_first, window_bitrate: r_rate,
                            last_result: !r_in.last_frame, default: '0};
        end else if (r_state == wbs_pkg::S_SQ_STEP && w_mul_done && r_bit == 6'd0) begin
            o_out_valid <= 1'b1;
            o_out_data <= '{
                result_kind: 1'b1,
                average_bitrate: r_avg,
                min_bitrate: (r_lo_rate < r_avg) ? r_lo_rate : r_avg,
                max_bitrate: (r_hi_rate > r_avg) ? r_hi_rate : r_avg,
                std_deviation: !r_sd_ok ? 40'd0 :
                    ((w_mul_p <= r_num)
                     ? ((w_cand[63:40] != '0) ? wbs_pkg::M40 : w_cand[39:0])
                     : ((r_sq_res[63:40] != '0) ? wbs_pkg::M40 : r_sq_res[39:0])),
                last_result: 1'b1,
                default: '0
            };
        end
    end

    assign o_in_stall = (r_state != wbs_pkg::S_IDLE);

    logic [48:0]  w_wb_sum;
    logic [56:0]  w_sb_sum;
    logic [64:0]  w_rs_sum;
    logic [128:0] w_sq_sum;
    logic [127:0] w_na2;
    logic [128:0] w_num_sum;
    assign w_wb_sum = {1'b0, (r_win_open ? r_win_bytes : 48'd0)} + 49'(r_in.frame_bytes);
    assign w_sb_sum = {1'b0, r_st_bytes} + 57'(r_in.frame_bytes);
    assign w_rs_sum = {1'b0, r_rate_sum} + 65'(r_rate);
    assign w_sq_sum = {1'b0, r_sq_sum} + {1'b0, w_mul_p};
    // Full n*a*a from its low part in r_num and its high part on the multiplier.
    assign w_na2 = r_num + {w_mul_p[63:0], 64'd0};
    assign w_num_sum = {1'b0, r_sq_sum} + {1'b0, w_na2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wbs_pkg::S_IDLE;
            r_window_ticks <= wbs_pkg::RST_WINDOW_TICKS;
            r_ticks_per_sec <= wbs_pkg::RST_TICKS_PER_SEC;
            r_fallback_fps <= wbs_pkg::RST_FALLBACK_FPS;
            r_win_open <= 1'b0;
            r_win_first <= '0; r_win_last <= '0; r_win_bytes <= '0; r_win_cnt <= '0;
            r_st_first <= '0; r_st_last <= '0; r_st_bytes <= '0; r_st_cnt <= '0;
            r_wcount <= '0; r_lo_rate <= wbs_pkg::M40; r_hi_rate <= '0;
            r_rate_sum <= '0; r_sq_sum <= '0;
            r_win_is_last <= 1'b0;
            r_sq_kick <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wbs_pkg::REG_WINDOW_TICKS:  r_window_ticks <= i_cfg_data;
                    wbs_pkg::REG_TICKS_PER_SEC: r_ticks_per_sec <= i_cfg_data[31:0];
                    wbs_pkg::REG_FALLBACK_FPS:  r_fallback_fps <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                wbs_pkg::S_IDLE: if (i_in_valid) r_in <= i_in_data;
                wbs_pkg::S_CHECK: r_win_is_last <= 1'b1;
                wbs_pkg::S_WR_WAIT: if (w_div_rsp.done) begin
                    r_rate <= (r_win_span_ok(w_win_span, r_ticks_per_sec,
                               r_fallback_fps, r_win_cnt)) ? w_q_sat : 40'd0;
                end
                wbs_pkg::S_WR_EMIT: if (w_mul_done) begin
                    if (r_wcount != '1) r_wcount <= r_wcount + 32'd1;
                    if (r_rate < r_lo_rate) r_lo_rate <= r_rate;
                    if (r_rate > r_hi_rate) r_hi_rate <= r_rate;
                    r_rate_sum <= w_rs_sum[64] ? '1 : w_rs_sum[63:0];
                    r_sq_sum <= w_sq_sum[128] ? '1 : w_sq_sum[127:0];
                    r_win_open <= 1'b0;
                end
                wbs_pkg::S_ACC: if (!r_win_is_last) begin
                    // Already merged; second pass after the final close.
                end else begin
                    r_win_is_last <= 1'b0;
                    if (!r_win_open) begin
                        r_win_first <= r_in.frame_timestamp;
                        r_win_cnt <= 32'd1;
                    end else if (r_win_cnt != '1) begin
                        r_win_cnt <= r_win_cnt + 32'd1;
                    end
                    r_win_open <= 1'b1;
                    r_win_last <= r_in.frame_timestamp;
                    r_win_bytes <= w_wb_sum[48] ? '1 : w_wb_sum[47:0];
                    if (r_st_cnt == '0) r_st_first <= r_in.frame_timestamp;
                    r_st_last <= r_in.frame_timestamp;
                    r_st_bytes <= w_sb_sum[56] ? '1 : w_sb_sum[55:0];
                    if (r_st_cnt != '1) r_st_cnt <= r_st_cnt + 32'd1;
                end
                wbs_pkg::S_AV_WAIT: if (w_div_rsp.done) begin
                    r_avg <= (r_win_span_ok(w_st_span, r_ticks_per_sec,
                              r_fallback_fps, r_st_cnt)) ? w_q_sat : 40'd0;
                end
                wbs_pkg::S_SD_MA: if (w_mul_done) r_tmp <= w_mul_p;
                wbs_pkg::S_SD_MB: if (w_mul_done) r_num <= w_mul_p;
                wbs_pkg::S_SD_MC: if (w_mul_done) begin
                    // r_num = S2 + n*a*a, saturated.
                    r_num <= w_num_sum[128] ? '1 : w_num_sum[127:0];
                end
                wbs_pkg::S_SD_SUB: if (w_mul_done) begin
                    r_tmp <= w_mul_p;
                    r_sd_ok <= (r_wcount != '0) && (w_mul_p <= r_num);
                end
                wbs_pkg::S_SD_DIV: begin
                    r_sq_res <= '0;
                    r_bit <= 6'd63;
                    r_sq_kick <= 1'b1;
                end
                wbs_pkg::S_SD_WAIT: if (w_div_rsp.done) r_num <= w_div_rsp.quo;
                wbs_pkg::S_SQ_STEP: begin
                    // One square per bit: start it, wait for it, then keep the bit if the square fits.
                    if (r_sq_kick) begin
                        r_sq_kick <= 1'b0;
                    end else if (w_mul_done) begin
                        if (w_mul_p <= r_num) r_sq_res <= w_cand;
                        if (r_bit != 6'd0) begin
                            r_bit <= r_bit - 6'd1;
                            r_sq_kick <= 1'b1;
                        end
                    end
                end
                wbs_pkg::S_SUM_OUT: if (w_out_take) begin
                    r_win_open <= 1'b0;
                    r_win_first <= '0; r_win_last <= '0; r_win_bytes <= '0;
                    r_win_cnt <= '0; r_st_first <= '0; r_st_last <= '0;
                    r_st_bytes <= '0; r_st_cnt <= '0; r_wcount <= '0;
                    r_lo_rate <= wbs_pkg::M40; r_hi_rate <= '0;
                    r_rate_sum <= '0; r_sq_sum <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: design/wbs_checker.sv
// Port-level checker for the windowed bitrate statistics core, bound to the
// top level. Depends on wbs_pkg.
module wbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input wbs_pkg::t_out_beat o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("frame accepted without going busy");

    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind |-> o_out_data.last_result)
        else $error("summary beat not marked last");

    a_window_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.result_kind |-> o_out_data.std_deviation == 40'd0)
        else $error("window beat carries summary field");
endmodule

bind windowed_bitrate_stats_core wbs_checker u_wbs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_data(o_out_data)
);
